// File: rtl/hbdm_pkg.sv
// shared types and constants of the task heartbeat deadline monitor
`default_nettype none

package hbdm_pkg;

  localparam int unsigned TaskCountDef = 9;
  localparam int unsigned MaxTasks     = 12;
  localparam int unsigned TimeW        = 32;

  // opcodes of the command field
  localparam logic [2:0] OP_HEARTBEAT   = 3'd0;
  localparam logic [2:0] OP_DELAY_UNTIL = 3'd1;
  localparam logic [2:0] OP_SCAN        = 3'd2;
  localparam logic [2:0] OP_CLEAR       = 3'd3;
  localparam logic [2:0] OP_QUERY       = 3'd4;

  // register indexes on the config port
  localparam logic [1:0] REG_TMO_LOW  = 2'd0;
  localparam logic [1:0] REG_TMO_MID  = 2'd1;
  localparam logic [1:0] REG_TMO_HIGH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEAT,
    ST_DLY_ADD,
    ST_DLY_CMP,
    ST_DLY_RESCHED,
    ST_DLY_COUNT,
    ST_SCAN_CHK,
    ST_SCAN_INC,
    ST_CLEAR,
    ST_RESULT
  } state_e;

  // operands of the shared adder
  typedef struct packed {
    logic [TimeW-1:0] a;
    logic [TimeW-1:0] b;
    logic             sub;
  } add_req_t;

endpackage

`default_nettype wire

// File: rtl/hbdm_addsub.sv
// shared 32-bit add/subtract unit used by the arithmetic sequencer steps
`default_nettype none

module hbdm_addsub (
  input  hbdm_pkg::add_req_t             req_i,
  output logic [hbdm_pkg::TimeW-1:0]     sum_o
);
  import hbdm_pkg::*;

  logic [TimeW-1:0] b_eff;

  // two's complement subtract: invert b and carry in one
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o = req_i.a + b_eff + {{(TimeW-1){1'b0}}, req_i.sub};

endmodule

`default_nettype wire

// File: rtl/task_heartbeat_deadline_monitor.sv
// top level: multi-task heartbeat watchdog with a sequencer around one shared adder
// steps: a query goes straight to the result, a heartbeat writes the beat first, a delay-until
//   adds, compares and may reschedule and count a miss, clear and scan walk every task
// throughput: one request at a time; the next is taken once the result is registered
//   (the adder is used once per step, a scan step per task plus one per new timeout)
// reset: asynchronous active low, clears all task state, timeouts and the output valid flag
`default_nettype none

module task_heartbeat_deadline_monitor #(
  parameter int unsigned TASK_COUNT = hbdm_pkg::TaskCountDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // request stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // opcode[2:0], task_req[6:3], now[38:7], previous_wake[70:39], period[102:71], zero pad
  input  wire logic [103:0]  s_axis_tdata,
  // result stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // wake_time[31:0], missed[32], timeout_mask[44:33], task_missed[76:45],
  // task_timeouts[108:77], task_last_seen[140:109], task_flag[141], zero pad
  output logic [143:0]       m_axis_tdata,
  // config port
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import hbdm_pkg::*;

  localparam int unsigned IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  // timeout registers
  logic [63:0] tmo_low_q, tmo_mid_q, tmo_high_q;
  logic        cfg_wr;

  // per-task state
  logic [TimeW-1:0]      last_beat_q [TASK_COUNT];
  logic [TimeW-1:0]      tmo_ev_q    [TASK_COUNT];
  logic [TimeW-1:0]      miss_ev_q   [TASK_COUNT];
  logic [TASK_COUNT-1:0] late_q;

  // latched request
  state_e           state_q, state_d;
  logic [TimeW-1:0] now_q, prev_q, period_q;
  logic             task_ok_q;
  logic [IW-1:0]    req_idx_q;
  logic [IW-1:0]    idx_q, idx_d;
  logic [TimeW-1:0] next_q, next_d;
  logic             miss_q, miss_d;

  // output stage
  logic         out_valid_q;
  logic [143:0] out_data_q;
  logic         out_load;

  // shared unit
  add_req_t         add_req;
  logic [TimeW-1:0] add_sum;

  // write strobes into the task state
  logic wr_beat, wr_miss, wr_tev, wr_clear, set_late;

  logic [15:0] tmo_tbl [MaxTasks];
  logic [15:0] tmo_cur;
  logic        accept;
  logic [3:0]  in_task;
  logic        in_task_ok;
  logic        scan_hit;
  logic        idx_last;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_low_q  <= '0;
      tmo_mid_q  <= '0;
      tmo_high_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_TMO_LOW:  tmo_low_q  <= pwdata;
        REG_TMO_MID:  tmo_mid_q  <= pwdata;
        REG_TMO_HIGH: tmo_high_q <= pwdata;
        default: ;  // index three is not a register
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_TMO_LOW:  prdata = tmo_low_q;
      REG_TMO_MID:  prdata = tmo_mid_q;
      REG_TMO_HIGH: prdata = tmo_high_q;
      default:      prdata = '0;
    endcase
  end

  // 16-bit timeout of each task, four to a register
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tmo_tbl[k]     = tmo_low_q[k*16 +: 16];
      tmo_tbl[k + 4] = tmo_mid_q[k*16 +: 16];
      tmo_tbl[k + 8] = tmo_high_q[k*16 +: 16];
    end
  end

  assign tmo_cur = tmo_tbl[idx_q];

  // ---------------- input side ----------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_task       = s_axis_tdata[6:3];
  assign in_task_ok    = ({1'b0, in_task} < 5'(TASK_COUNT));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q     <= s_axis_tdata[38:7];
      prev_q    <= s_axis_tdata[70:39];
      period_q  <= s_axis_tdata[102:71];
      task_ok_q <= in_task_ok;
      req_idx_q <= in_task_ok ? IW'(in_task) : '0;
    end
  end

  // ---------------- shared adder ----------------
  hbdm_addsub u_addsub (
    .req_i (add_req),
    .sum_o (add_sum)
  );

  // operand select per sequencer step
  always_comb begin
    add_req = '0;
    case (state_q)
      ST_DLY_ADD: begin
        add_req.a = prev_q;
        add_req.b = period_q;
      end
      ST_DLY_CMP: begin
        add_req.a   = now_q;
        add_req.b   = next_q;
        add_req.sub = 1'b1;
      end
      ST_DLY_RESCHED: begin
        add_req.a = now_q;
        add_req.b = period_q;
      end
      ST_DLY_COUNT: begin
        add_req.a = miss_ev_q[idx_q];
        add_req.b = TimeW'(1);
      end
      ST_SCAN_CHK: begin
        // ticks since last heartbeat, modulo 2^32
        add_req.a   = now_q;
        add_req.b   = last_beat_q[idx_q];
        add_req.sub = 1'b1;
      end
      ST_SCAN_INC: begin
        add_req.a = tmo_ev_q[idx_q];
        add_req.b = TimeW'(1);
      end
      default: ;
    endcase
  end

  // task is enabled and silent longer than its timeout
  assign scan_hit = (last_beat_q[idx_q] != '0) && (tmo_cur != '0) &&
                    (add_sum > {16'b0, tmo_cur});
  assign idx_last = (idx_q == IW'(TASK_COUNT - 1));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q <= next_d;
    miss_q <= miss_d;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    next_d   = next_q;
    miss_d   = miss_q;
    wr_beat  = 1'b0;
    wr_miss  = 1'b0;
    wr_tev   = 1'b0;
    wr_clear = 1'b0;
    set_late = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          next_d = s_axis_tdata[70:39];
          miss_d = 1'b0;
          idx_d  = in_task_ok ? IW'(in_task) : '0;
          case (s_axis_tdata[2:0])
            OP_HEARTBEAT:   state_d = ST_BEAT;
            OP_DELAY_UNTIL: state_d = ST_DLY_ADD;
            OP_SCAN: begin
              state_d = ST_SCAN_CHK;
              idx_d   = '0;
            end
            OP_CLEAR: begin
              state_d = ST_CLEAR;
              idx_d   = '0;
            end
            default:        state_d = ST_RESULT;  // query and unused codes
          endcase
        end
      end
      ST_BEAT: begin
        wr_beat = task_ok_q;
        state_d = ST_RESULT;
      end
      ST_DLY_ADD: begin
        if (period_q == '0) begin
          state_d = ST_RESULT;
        end else begin
          wr_beat = task_ok_q;
          next_d  = add_sum;
          state_d = ST_DLY_CMP;
        end
      end
      ST_DLY_CMP: begin
        // wrap-safe: deadline reached when now - next is not negative
        state_d = add_sum[TimeW-1] ? ST_RESULT : ST_DLY_RESCHED;
      end
      ST_DLY_RESCHED: begin
        next_d  = add_sum;
        miss_d  = 1'b1;
        state_d = task_ok_q ? ST_DLY_COUNT : ST_RESULT;
      end
      ST_DLY_COUNT: begin
        wr_miss = 1'b1;
        state_d = ST_RESULT;
      end
      ST_SCAN_CHK: begin
        if (scan_hit && !late_q[idx_q]) begin
          state_d = ST_SCAN_INC;
        end else begin
          // no timeout, or flag already set and not counted again
          if (idx_last) begin
            idx_d   = req_idx_q;
            state_d = ST_RESULT;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      ST_SCAN_INC: begin
        wr_tev   = 1'b1;
        set_late = 1'b1;
        if (idx_last) begin
          idx_d   = req_idx_q;
          state_d = ST_RESULT;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_SCAN_CHK;
        end
      end
      ST_CLEAR: begin
        wr_clear = 1'b1;
        if (idx_last) begin
          idx_d   = req_idx_q;
          state_d = ST_RESULT;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_RESULT: begin
        // wait while an older result still sits in the output stage
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- task state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TASK_COUNT; k++) begin
        last_beat_q[k] <= '0;
        tmo_ev_q[k]    <= '0;
        miss_ev_q[k]   <= '0;
      end
      late_q <= '0;
    end else begin
      if (wr_beat) begin
        last_beat_q[idx_q] <= now_q;
        late_q[idx_q]      <= 1'b0;
      end
      if (wr_miss) begin
        miss_ev_q[idx_q] <= add_sum;
      end
      if (wr_tev) begin
        tmo_ev_q[idx_q] <= add_sum;
      end
      if (set_late) begin
        late_q[idx_q] <= 1'b1;
      end
      if (wr_clear) begin
        last_beat_q[idx_q] <= '0;
        tmo_ev_q[idx_q]    <= '0;
        miss_ev_q[idx_q]   <= '0;
        late_q[idx_q]      <= 1'b0;
      end
    end
  end

  // ---------------- output stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q[31:0]    <= next_q;
      out_data_q[32]      <= miss_q;
      out_data_q[44:33]   <= 12'(late_q);
      out_data_q[76:45]   <= task_ok_q ? miss_ev_q[idx_q] : '0;
      out_data_q[108:77]  <= task_ok_q ? tmo_ev_q[idx_q] : '0;
      out_data_q[140:109] <= task_ok_q ? last_beat_q[idx_q] : '0;
      out_data_q[141]     <= task_ok_q & late_q[idx_q];
      out_data_q[143:142] <= '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// testbench: heartbeat deadline monitor checked request by request against a behavioral model

module tb_top;
  import hbdm_pkg::*;

  localparam int unsigned TASK_N        = TaskCountDef;
  // longest step is a scan that raises every flag, plus margin
  localparam int unsigned SETTLE_CYCLES = 2 * TASK_N + 4;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned LONG_HOLD     = 300;

  // register slot past the last timeout register, writes to it are dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // opcodes with no meaning of their own, they act as a query
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  // request word, highest field first in the bit order of the port
  typedef struct packed {
    logic        pad;
    logic [31:0] period;
    logic [31:0] prev_wake;
    logic [31:0] now;
    logic [3:0]  task_idx;
    logic [2:0]  opcode;
  } wd_cmd_t;

  // result word
  typedef struct packed {
    logic [1:0]  pad;
    logic        flag;
    logic [31:0] last_seen;
    logic [31:0] timeouts;
    logic [31:0] missed_cnt;
    logic [11:0] mask;
    logic        missed;
    logic [31:0] wake_time;
  } wd_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata  = '0;

  // result side
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;

  // config port
  logic         psel    = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite  = 1'b0;
  logic [4:0]   paddr   = '0;
  logic [63:0]  pwdata  = '0;
  logic [63:0]  prdata;
  logic         pready;

  // watchdog model: per task last beat, timed-out flag and the two event counters
  logic [31:0] beat_ms     [TASK_N] = '{default: '0};
  logic        late        [TASK_N] = '{default: 1'b0};
  logic [31:0] tmo_count   [TASK_N] = '{default: '0};
  logic [31:0] miss_count  [TASK_N] = '{default: '0};
  logic [63:0] tmo_regs    [3]      = '{default: '0};

  // results still owed by the block, oldest first
  wd_result_t expected_results[$];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  // no idling on that side while set
  bit          steady_src    = 1'b0;
  bit          steady_sink   = 1'b0;
  // nonzero asks the result sink for one long hold-off of that many cycles
  int unsigned sink_hold_len = 0;

  wd_result_t seen_res;
  wd_result_t want_res;

  task_heartbeat_deadline_monitor #(
    .TASK_COUNT(TASK_N)
  ) DUT (
    .*
  );

  always #5 clk_i = ~clk_i;

  // hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // gap length for either side: mostly none, some short, a few long
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // timeout of one task, 16-bit lanes packed four to a register
  function automatic logic [15:0] task_limit(input int unsigned t);
    return tmo_regs[t / 4][(t % 4) * 16 +: 16];
  endfunction

  // timeout register value with four short random lanes, some of them disabled
  function automatic logic [63:0] short_timeouts(input int unsigned longest);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 7) != 0) v[k * 16 +: 16] = 16'($urandom_range(1, longest));
    end
    return v;
  endfunction

  // apply one command to the model state and return the result it should give
  function automatic wd_result_t apply_command(input wd_cmd_t c);
    wd_result_t  r;
    logic [31:0] wake;
    logic [31:0] lag;
    logic [31:0] silent;
    logic        hit;
    r    = '0;
    hit  = (c.task_idx < TASK_N);
    wake = c.prev_wake;
    case (c.opcode)
      OP_HEARTBEAT: begin
        if (hit) begin
          beat_ms[c.task_idx] = c.now;
          late[c.task_idx]    = 1'b0;
        end
      end
      OP_DELAY_UNTIL: begin
        // zero period leaves everything untouched
        if (c.period != '0) begin
          if (hit) begin
            beat_ms[c.task_idx] = c.now;
            late[c.task_idx]    = 1'b0;
          end
          wake = c.prev_wake + c.period;
          lag  = c.now - wake;
          // deadline reached when now is not before the wake time, modulo wrap
          if (!lag[31]) begin
            wake     = c.now + c.period;
            r.missed = 1'b1;
            if (hit) miss_count[c.task_idx] = miss_count[c.task_idx] + 1;
          end
        end
      end
      OP_SCAN: begin
        for (int i = 0; i < TASK_N; i++) begin
          silent = c.now - beat_ms[i];
          // never-seen tasks and disabled timeouts are skipped
          if (beat_ms[i] != '0 && task_limit(i) != '0 && silent > {16'd0, task_limit(i)}) begin
            if (!late[i]) tmo_count[i] = tmo_count[i] + 1;
            late[i] = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < TASK_N; i++) begin
          beat_ms[i]    = '0;
          late[i]       = 1'b0;
          tmo_count[i]  = '0;
          miss_count[i] = '0;
        end
      end
      default: ;
    endcase
    r.wake_time = wake;
    for (int i = 0; i < TASK_N; i++) r.mask[i] = late[i];
    if (hit) begin
      r.missed_cnt = miss_count[c.task_idx];
      r.timeouts   = tmo_count[c.task_idx];
      r.last_seen  = beat_ms[c.task_idx];
      r.flag       = late[c.task_idx];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  // result checker, samples at the edge that completes the handshake
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      seen_res = m_axis_tdata;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", seen_res.wake_time, '0);
      end else begin
        want_res = expected_results.pop_front();
        if (seen_res.wake_time !== want_res.wake_time)
          report_mismatch("wake_time", seen_res.wake_time, want_res.wake_time);
        if (seen_res.missed !== want_res.missed)
          report_mismatch("missed", 32'(seen_res.missed), 32'(want_res.missed));
        if (seen_res.mask !== want_res.mask)
          report_mismatch("timeout_mask", 32'(seen_res.mask), 32'(want_res.mask));
        if (seen_res.missed_cnt !== want_res.missed_cnt)
          report_mismatch("task_missed", seen_res.missed_cnt, want_res.missed_cnt);
        if (seen_res.timeouts !== want_res.timeouts)
          report_mismatch("task_timeouts", seen_res.timeouts, want_res.timeouts);
        if (seen_res.last_seen !== want_res.last_seen)
          report_mismatch("task_last_seen", seen_res.last_seen, want_res.last_seen);
        if (seen_res.flag !== want_res.flag)
          report_mismatch("task_flag", 32'(seen_res.flag), 32'(want_res.flag));
      end
    end
  end

  // result sink: random stalls, plus a long hold-off on demand counted here
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold_len != 0) begin
        stall         = sink_hold_len;
        sink_hold_len = 0;
      end else begin
        stall = pick_gap(steady_sink);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // offer one request, wait for it to be taken, then idle for a random gap;
  // with no gap tvalid stays high for the next request
  task automatic send_command(input logic [2:0] op, input logic [3:0] idx,
                              input logic [31:0] now, input logic [31:0] prev,
                              input logic [31:0] period);
    wd_cmd_t     c;
    int unsigned gap;
    c.pad       = 1'b0;
    c.opcode    = op;
    c.task_idx  = idx;
    c.now       = now;
    c.prev_wake = prev;
    c.period    = period;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_results.push_back(apply_command(c));
    gap = pick_gap(steady_src);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending, let every owed result arrive, then let the sequencer settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // config write while the block is idle, then read back a real register
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == REG_UNUSED) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      tmo_regs[idx] = value;
      // straight into the setup phase of the read
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(negedge clk_i);
      if (prdata[31:0] !== value[31:0])
        report_mismatch("readback low word", prdata[31:0], value[31:0]);
      if (prdata[63:32] !== value[63:32])
        report_mismatch("readback high word", prdata[63:32], value[63:32]);
      do @(posedge clk_i); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // task state reads zero right after reset, valid and invalid index alike
  task automatic test_after_reset();
    send_command(OP_QUERY, 4'd0, $urandom, $urandom, $urandom);
    send_command(OP_QUERY, 4'd15, $urandom, $urandom, $urandom);
    // scan with no timeouts set and nothing seen flags nothing
    send_command(OP_SCAN, 4'd8, 32'hFFFF_FFFF, '0, '0);
  endtask

  // scan thresholds, never-seen and disabled tasks, no double counting
  task automatic test_timeout_scan();
    // task 0 10 ms, task 1 100 ms, task 2 the longest, task 3 disabled
    write_reg(REG_TMO_LOW, {16'd0, 16'hFFFF, 16'd100, 16'd10});
    write_reg(REG_TMO_MID, {16'd4, 16'd3, 16'd2, 16'd1});
    // lanes past the last task must not matter
    write_reg(REG_TMO_HIGH, {16'hABCD, 16'h1234, 16'h5678, 16'd50});
    send_command(OP_HEARTBEAT, 4'd0, 32'd1000, $urandom, $urandom);
    send_command(OP_HEARTBEAT, 4'd3, 32'd1000, $urandom, $urandom);
    // beat at tick zero marks the task never seen
    send_command(OP_HEARTBEAT, 4'd1, 32'd0, $urandom, $urandom);
    // out of range index is ignored
    send_command(OP_HEARTBEAT, 4'd9, 32'd1000, $urandom, $urandom);
    // silent exactly the timeout is still fine, one more tick is not
    send_command(OP_SCAN, 4'd0, 32'd1010, $urandom, $urandom);
    send_command(OP_SCAN, 4'd0, 32'd1011, $urandom, $urandom);
    // already timed out: flag stays, count does not move
    send_command(OP_SCAN, 4'd3, 32'd5000, $urandom, $urandom);
    send_command(OP_QUERY, 4'd0, $urandom, $urandom, $urandom);
    send_command(OP_HEARTBEAT, 4'd0, 32'd5001, $urandom, $urandom);
    // silence measured across the wrap of the tick
    send_command(OP_HEARTBEAT, 4'd2, 32'hFFFF_FFF0, $urandom, $urandom);
    send_command(OP_SCAN, 4'd2, 32'h0001_0000, $urandom, $urandom);
    send_command(OP_QUERY, 4'd1, $urandom, $urandom, $urandom);
  endtask

  // next wake time, missed deadlines and the signed wrap-safe compare
  task automatic test_delay_until();
    // zero period does nothing at all
    send_command(OP_DELAY_UNTIL, 4'd4, 32'd100, 32'd50, 32'd0);
    send_command(OP_DELAY_UNTIL, 4'd4, 32'd100, 32'd100, 32'd20);
    // deadline reached exactly counts as missed
    send_command(OP_DELAY_UNTIL, 4'd4, 32'd120, 32'd100, 32'd20);
    // wake time wraps past zero, still in the future
    send_command(OP_DELAY_UNTIL, 4'd5, 32'h0000_0005, 32'hFFFF_FFF0, 32'h20);
    // invalid index still computes the wake but keeps no state
    send_command(OP_DELAY_UNTIL, 4'd12, 32'd300, 32'd0, 32'd10);
    send_command(OP_DELAY_UNTIL, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_QUERY, 4'd4, $urandom, $urandom, $urandom);
  endtask

  // spare opcodes act as query, clear wipes task state but not the timeouts
  task automatic test_clear_and_unused();
    send_command(OP_SPARE_LO, 4'd0, $urandom, $urandom, $urandom);
    send_command(OP_SPARE_MID, 4'd2, $urandom, $urandom, $urandom);
    send_command(OP_SPARE_HI, 4'd4, $urandom, $urandom, $urandom);
    send_command(OP_CLEAR, 4'd0, $urandom, $urandom, $urandom);
    send_command(OP_QUERY, 4'd2, $urandom, $urandom, $urandom);
  endtask

  // well-formed schedules on a moving tick under several timeout settings
  task automatic test_random_traffic();
    logic [63:0] lo, mid, hi;
    logic [31:0] tick, prev, per;
    logic [2:0]  op;
    logic [3:0]  idx;
    int unsigned sel, r;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: begin
          // longest possible timeouts everywhere
          lo = '1; mid = '1; hi = '1;
        end
        2: begin
          // every task disabled
          lo = '0; mid = '0; hi = '0;
        end
        3: begin
          lo = {$urandom, $urandom}; mid = {$urandom, $urandom}; hi = {$urandom, $urandom};
        end
        5: begin
          lo = short_timeouts(40); mid = short_timeouts(40); hi = short_timeouts(40);
        end
        default: begin
          lo = short_timeouts(300); mid = short_timeouts(300); hi = short_timeouts(300);
        end
      endcase
      write_reg(REG_TMO_LOW, lo);
      write_reg(REG_TMO_MID, mid);
      write_reg(REG_TMO_HIGH, hi);
      if (p == 1) write_reg(REG_UNUSED, {$urandom, $urandom});
      steady_src  = (p == 2);
      steady_sink = (p == 3);
      // one phase runs the tick through zero
      tick = (p == 4) ? 32'hFFFF_F000 : 32'($urandom_range(1, 1_000_000));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pause until the block has answered everything
        if (n == PHASE_ITEMS / 2) drain_results();
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) idx = 4'($urandom_range(TASK_N, 15));
        else idx = 4'($urandom_range(0, TASK_N - 1));
        if (sel < 30) op = OP_HEARTBEAT;
        else if (sel < 55) op = OP_DELAY_UNTIL;
        else if (sel < 80) op = OP_SCAN;
        else if (sel < 94) op = OP_QUERY;
        else if (sel < 96) op = OP_CLEAR;
        else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        r = $urandom_range(0, 19);
        if (r == 0) per = '0;
        else if (r == 1) per = $urandom;
        else per = 32'($urandom_range(1, 150));
        // previous wake scattered around the tick, late and early
        prev = tick + 32'($urandom_range(0, 300)) - 32'd150;
        if ($urandom_range(0, 19) == 0) tick = tick + 32'($urandom_range(200, 3000));
        else tick = tick + 32'($urandom_range(0, 25));
        send_command(op, idx, tick, prev, per);
      end
    end
    steady_src  = 1'b0;
    steady_sink = 1'b0;
  endtask

  // sink holds off for a long stretch while requests keep coming back to back
  task automatic test_backpressure();
    steady_src    = 1'b1;
    sink_hold_len = LONG_HOLD;
    for (int n = 0; n < 24; n++) begin
      send_command(3'($urandom_range(OP_HEARTBEAT, OP_QUERY)), 4'($urandom_range(0, 15)),
                   32'($urandom_range(1, 5000)), $urandom, 32'($urandom_range(0, 100)));
    end
    drain_results();
    steady_src = 1'b0;
  endtask

  // unconstrained requests: any opcode, index and full-width times
  task automatic test_noise();
    for (int n = 0; n < 150; n++) begin
      send_command(3'($urandom), 4'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_timeout_scan();
    test_delay_until();
    test_clear_and_unused();
    test_random_traffic();
    test_backpressure();
    test_noise();
    drain_results();
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hbdm_pkg.sv
rtl/hbdm_addsub.sv
rtl/task_heartbeat_deadline_monitor.sv
verif/tb_top.sv
